/* rtl/droplet_valve_sequencer_core_assert.svh */
// Assertion macros shared by the droplet valve sequencer RTL.
`ifndef DROPLET_VALVE_SEQUENCER_CORE_ASSERT_SVH
`define DROPLET_VALVE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DVS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dvs: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dvs: next-cycle check failed");

`endif

/* rtl/dvs_pkg.sv */
// Types and constants of the droplet valve sequencer.
package dvs_pkg;

   // operation codes
   localparam logic [2:0] OP_TICK           = 3'd0;
   localparam logic [2:0] OP_START          = 3'd1;
   localparam logic [2:0] OP_RESET_COUNTS   = 3'd2;
   localparam logic [2:0] OP_DISABLE_PRINT  = 3'd3;
   localparam logic [2:0] OP_DISABLE_REFUEL = 3'd4;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_PRINT_INTERVAL      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REFUEL_DELAY        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PRINT_PULSE_LENGTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_REFUEL_PULSE_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESSURE_TOLERANCE  = 3'd4;

   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned TOL_W      = 15;
   localparam int unsigned DROPLET_W  = 16;
   localparam int unsigned PRESS_W    = 16;
   localparam int unsigned OUT_CNT_W  = 16;

   // retry waits in ticks
   localparam int unsigned RETRY_LONG  = 10000;
   localparam int unsigned RETRY_SHORT = 1000;

   localparam logic [CSR_DATA_W-1:0] RST_PRINT_INTERVAL = 20'd50000;
   localparam logic [CSR_DATA_W-1:0] RST_REFUEL_DELAY   = 20'd25000;
   localparam logic [CSR_DATA_W-1:0] RST_PULSE_LENGTH   = 20'd4200;
   localparam logic [TOL_W-1:0]      RST_TOLERANCE      = 15'd20;

   typedef struct packed {
      logic [2:0]                 operation;
      logic [DROPLET_W-1:0]       droplet_count;
      logic                       paused;
      logic                       print_reg_resetting;
      logic                       print_reg_active;
      logic signed [PRESS_W-1:0]  print_pressure;
      logic signed [PRESS_W-1:0]  print_setpoint;
      logic                       refuel_reg_resetting;
      logic                       refuel_reg_active;
      logic signed [PRESS_W-1:0]  refuel_pressure;
      logic signed [PRESS_W-1:0]  refuel_setpoint;
   } step_in_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] print_interval;
      logic [CSR_DATA_W-1:0] refuel_delay;
      logic [CSR_DATA_W-1:0] print_pulse_length;
      logic [CSR_DATA_W-1:0] refuel_pulse_length;
      logic [TOL_W-1:0]      pressure_tolerance;
   } cfg_type;

   typedef struct packed {
      logic                 print_valve;
      logic                 refuel_valve;
      logic                 printing_done;
      logic [OUT_CNT_W-1:0] printed_count;
   } result_type;

   // |pressure - setpoint| > tolerance, exact in 17 bits
   function automatic logic err_too_big(logic signed [PRESS_W-1:0] p,
                                        logic signed [PRESS_W-1:0] sp,
                                        logic [TOL_W-1:0] tol);
      logic signed [PRESS_W:0] diff;
      logic [PRESS_W:0]        mag;
      diff = (PRESS_W+1)'(p) - (PRESS_W+1)'(sp);
      mag  = diff[PRESS_W] ? (PRESS_W+1)'(-diff) : (PRESS_W+1)'(diff);
      return mag > (PRESS_W+1)'(tol);
   endfunction

endpackage

/* rtl/droplet_valve_sequencer_core.sv */
// Top level of the droplet valve sequencer: word channels around the scheduler.
//
// Usage:
//  - req_* carries one word per microsecond tick: an operation (tick, start,
//    reset counts, disable print, disable refuel), the droplet count for start,
//    and the pause, regulator and pressure readings for that tick.
//  - rsp_* returns one word per request word: both valve drives, the done
//    flag and the printed droplet count after that tick.
//  - csr_* writes the timing and tolerance registers; write only while idle.
//  - The accepting edge loads the input register; the scheduler update for
//    that word lands in the response register once that register is free.
//  - Throughput is one word per cycle while rsp_stall is low; the scheduler
//    state update is one pass of logic between the input and response registers.
//  - The input register takes a new word while a finished response still
//    waits, so one stalled response does not stop the request side at once.
//    A stalled response holds its word; req_stall rises only when both the
//    input register and the response register are full and rsp_stall is high.
//  - Synchronous reset clears both valid flags, restores register defaults,
//    empties both task slots, zeroes the counts and sets the done flag.
`include "droplet_valve_sequencer_core_assert.svh"

module droplet_valve_sequencer_core #(
   parameter int unsigned COUNT_BITS = 16,
   parameter int unsigned TIME_BITS  = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_operation,
   input  logic [dvs_pkg::DROPLET_W-1:0]        req_droplet_count,
   input  logic                                 req_paused,
   input  logic                                 req_print_reg_resetting,
   input  logic                                 req_print_reg_active,
   input  logic signed [dvs_pkg::PRESS_W-1:0]   req_print_pressure,
   input  logic signed [dvs_pkg::PRESS_W-1:0]   req_print_setpoint,
   input  logic                                 req_refuel_reg_resetting,
   input  logic                                 req_refuel_reg_active,
   input  logic signed [dvs_pkg::PRESS_W-1:0]   req_refuel_pressure,
   input  logic signed [dvs_pkg::PRESS_W-1:0]   req_refuel_setpoint,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_print_valve,
   output logic                                 rsp_refuel_valve,
   output logic                                 rsp_printing_done,
   output logic [dvs_pkg::OUT_CNT_W-1:0]        rsp_printed_count,
   input  logic                                 csr_wr_en,
   input  logic [dvs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dvs_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import dvs_pkg::*;

   step_in_type in_data_ff, in_data_in;
   logic        in_valid_ff, in_valid_in;
   result_type  rsp_data_ff, step_result;
   logic        rsp_valid_ff, rsp_valid_in;
   cfg_type     cfg;
   logic        advance;
   logic        step_en;
   logic        req_take;

   // response register frees up when empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_data_in.operation            = req_operation;
      in_data_in.droplet_count        = req_droplet_count;
      in_data_in.paused               = req_paused;
      in_data_in.print_reg_resetting  = req_print_reg_resetting;
      in_data_in.print_reg_active     = req_print_reg_active;
      in_data_in.print_pressure       = req_print_pressure;
      in_data_in.print_setpoint       = req_print_setpoint;
      in_data_in.refuel_reg_resetting = req_refuel_reg_resetting;
      in_data_in.refuel_reg_active    = req_refuel_reg_active;
      in_data_in.refuel_pressure      = req_refuel_pressure;
      in_data_in.refuel_setpoint      = req_refuel_setpoint;
   end

   assign in_valid_in  = req_take ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step_en ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take)
         in_data_ff <= in_data_in;
      if (step_en)
         rsp_data_ff <= step_result;
   end

   dvs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .index   (csr_index),
      .wr_data (csr_wr_data),
      .cfg     (cfg)
   );

   dvs_sched #(
      .COUNT_BITS (COUNT_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_sched (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .step_in (in_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_print_valve   = rsp_data_ff.print_valve;
   assign rsp_refuel_valve  = rsp_data_ff.refuel_valve;
   assign rsp_printing_done = rsp_data_ff.printing_done;
   assign rsp_printed_count = rsp_data_ff.printed_count;

   // a processed word always shows up as a response
   `DVS_ASSERT_NEXT(a_step_fills_rsp, clock, reset, step_en, rsp_valid_ff)
   // back-pressure only with a word held in the input register
   `DVS_ASSERT_IMPLY(a_stall_needs_word, clock, reset, req_stall, in_valid_ff && rsp_valid_ff)

endmodule

/* rtl/dvs_csr.sv */
// Configuration registers of the droplet valve sequencer.
module dvs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [dvs_pkg::CSR_INDEX_W-1:0]  index,
   input  logic [dvs_pkg::CSR_DATA_W-1:0]   wr_data,
   output dvs_pkg::cfg_type                 cfg
);
   import dvs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_PRINT_INTERVAL:      cfg_in.print_interval      = wr_data;
            REG_REFUEL_DELAY:        cfg_in.refuel_delay        = wr_data;
            REG_PRINT_PULSE_LENGTH:  cfg_in.print_pulse_length  = wr_data;
            REG_REFUEL_PULSE_LENGTH: cfg_in.refuel_pulse_length = wr_data;
            REG_PRESSURE_TOLERANCE:  cfg_in.pressure_tolerance  = wr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.print_interval      <= RST_PRINT_INTERVAL;
         cfg_ff.refuel_delay        <= RST_REFUEL_DELAY;
         cfg_ff.print_pulse_length  <= RST_PULSE_LENGTH;
         cfg_ff.refuel_pulse_length <= RST_PULSE_LENGTH;
         cfg_ff.pressure_tolerance  <= RST_TOLERANCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/dvs_sched.sv */
// Task scheduler state and per-tick update of the droplet valve sequencer.
`include "droplet_valve_sequencer_core_assert.svh"

module dvs_sched #(
   parameter int unsigned COUNT_BITS = 16,
   parameter int unsigned TIME_BITS  = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  dvs_pkg::step_in_type step_in,
   input  dvs_pkg::cfg_type     cfg,
   output dvs_pkg::result_type  result
);
   import dvs_pkg::*;

   localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [TIME_BITS-1:0]  T_LONG    = TIME_BITS'(RETRY_LONG);
   localparam logic [TIME_BITS-1:0]  T_SHORT   = TIME_BITS'(RETRY_SHORT);

   function automatic logic [TIME_BITS-1:0] clamp_time(logic [CSR_DATA_W-1:0] v);
      return (32'(v) > 32'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(v);
   endfunction

   logic [TIME_BITS-1:0]  print_wait_ff, print_wait_in;
   logic [TIME_BITS-1:0]  refuel_wait_ff, refuel_wait_in;
   logic [TIME_BITS-1:0]  print_pulse_left_ff, print_pulse_left_in;
   logic [TIME_BITS-1:0]  refuel_pulse_left_ff, refuel_pulse_left_in;
   logic [COUNT_BITS-1:0] target_total_ff, target_total_in;
   logic [COUNT_BITS-1:0] printed_total_ff, printed_total_in;
   logic print_pending_ff, print_pending_in;
   logic refuel_pending_ff, refuel_pending_in;
   logic done_flag_ff, done_flag_in;
   logic reset_seen_ff, reset_seen_in;
   logic refuel_wanted_ff, refuel_wanted_in;
   logic print_enable_ff, print_enable_in;
   logic refuel_enable_ff, refuel_enable_in;

   always_comb begin
      logic [32:0] tsum;
      print_wait_in        = print_wait_ff;
      refuel_wait_in       = refuel_wait_ff;
      print_pulse_left_in  = print_pulse_left_ff;
      refuel_pulse_left_in = refuel_pulse_left_ff;
      target_total_in      = target_total_ff;
      printed_total_in     = printed_total_ff;
      print_pending_in     = print_pending_ff;
      refuel_pending_in    = refuel_pending_ff;
      done_flag_in         = done_flag_ff;
      reset_seen_in        = reset_seen_ff;
      refuel_wanted_in     = refuel_wanted_ff;
      print_enable_in      = print_enable_ff;
      refuel_enable_in     = refuel_enable_ff;
      tsum = 33'(target_total_ff) + 33'(step_in.droplet_count);

      // operation first
      case (step_in.operation)
         OP_START: begin
            target_total_in  = (tsum > 33'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(tsum);
            done_flag_in     = 1'b0;
            print_pending_in = 1'b1;
            print_wait_in    = '0;
         end
         OP_RESET_COUNTS: begin
            target_total_in  = '0;
            printed_total_in = '0;
            done_flag_in     = 1'b1;
            reset_seen_in    = 1'b0;
         end
         OP_DISABLE_PRINT:  print_enable_in  = 1'b0;
         OP_DISABLE_REFUEL: refuel_enable_in = 1'b0;
         default: ;
      endcase

      // print task
      if (print_pending_in && print_wait_in == '0) begin
         print_pending_in = 1'b0;
         if (step_in.paused) begin
            print_pending_in = 1'b1;
            print_wait_in    = T_LONG;
         end else if (printed_total_in >= target_total_in) begin
            done_flag_in     = 1'b1;
            print_enable_in  = 1'b1;
            refuel_enable_in = 1'b1;
         end else if (refuel_wanted_in) begin
            refuel_pending_in = 1'b1;
            refuel_wait_in    = '0;
            print_pending_in  = 1'b1;
            print_wait_in     = T_LONG;
         end else if (step_in.print_reg_resetting) begin
            reset_seen_in    = 1'b1;
            print_pending_in = 1'b1;
            print_wait_in    = T_LONG;
         end else begin
            reset_seen_in = 1'b0;
            if (step_in.print_reg_active &&
                err_too_big(step_in.print_pressure, step_in.print_setpoint,
                            cfg.pressure_tolerance)) begin
               print_pending_in = 1'b1;
               print_wait_in    = T_SHORT;
            end else begin
               if (print_enable_in)
                  print_pulse_left_in = clamp_time(cfg.print_pulse_length);
               refuel_wanted_in = 1'b1;
               if (printed_total_in != COUNT_MAX)
                  printed_total_in = printed_total_in + 1'b1;
               refuel_pending_in = 1'b1;
               refuel_wait_in    = clamp_time(cfg.refuel_delay);
               print_pending_in  = 1'b1;
               print_wait_in     = clamp_time(cfg.print_interval);
            end
         end
      end

      // refuel task, sees what the print task left
      if (refuel_pending_in && refuel_wait_in == '0) begin
         refuel_pending_in = 1'b0;
         if (step_in.paused) begin
            refuel_pending_in = 1'b1;
            refuel_wait_in    = T_LONG;
         end else if (!refuel_wanted_in) begin
            refuel_pending_in = 1'b0;
         end else if (step_in.refuel_reg_resetting) begin
            refuel_pending_in = 1'b1;
            refuel_wait_in    = T_LONG;
         end else if (step_in.refuel_reg_active &&
                      err_too_big(step_in.refuel_pressure, step_in.refuel_setpoint,
                                  cfg.pressure_tolerance)) begin
            refuel_pending_in = 1'b1;
            refuel_wait_in    = T_SHORT;
         end else begin
            if (refuel_enable_in)
               refuel_pulse_left_in = clamp_time(cfg.refuel_pulse_length);
            refuel_wanted_in = 1'b0;
         end
      end

      result.print_valve   = (print_pulse_left_in != '0);
      result.refuel_valve  = (refuel_pulse_left_in != '0);
      result.printing_done = done_flag_in;
      result.printed_count = OUT_CNT_W'(printed_total_in);

      // countdowns
      if (print_pulse_left_in != '0)
         print_pulse_left_in = print_pulse_left_in - 1'b1;
      if (refuel_pulse_left_in != '0)
         refuel_pulse_left_in = refuel_pulse_left_in - 1'b1;
      if (print_pending_in && print_wait_in != '0)
         print_wait_in = print_wait_in - 1'b1;
      if (refuel_pending_in && refuel_wait_in != '0)
         refuel_wait_in = refuel_wait_in - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         print_wait_ff        <= '0;
         refuel_wait_ff       <= '0;
         print_pulse_left_ff  <= '0;
         refuel_pulse_left_ff <= '0;
         target_total_ff      <= '0;
         printed_total_ff     <= '0;
         print_pending_ff     <= 1'b0;
         refuel_pending_ff    <= 1'b0;
         done_flag_ff         <= 1'b1;
         reset_seen_ff        <= 1'b0;
         refuel_wanted_ff     <= 1'b0;
         print_enable_ff      <= 1'b1;
         refuel_enable_ff     <= 1'b1;
      end else if (step_en) begin
         print_wait_ff        <= print_wait_in;
         refuel_wait_ff       <= refuel_wait_in;
         print_pulse_left_ff  <= print_pulse_left_in;
         refuel_pulse_left_ff <= refuel_pulse_left_in;
         target_total_ff      <= target_total_in;
         printed_total_ff     <= printed_total_in;
         print_pending_ff     <= print_pending_in;
         refuel_pending_ff    <= refuel_pending_in;
         done_flag_ff         <= done_flag_in;
         reset_seen_ff        <= reset_seen_in;
         refuel_wanted_ff     <= refuel_wanted_in;
         print_enable_ff      <= print_enable_in;
         refuel_enable_ff     <= refuel_enable_in;
      end
   end

   // an idle slot always has a spent wait
   `DVS_ASSERT_IMPLY(a_print_idle_wait, clock, reset, !print_pending_ff, print_wait_ff == '0)
   `DVS_ASSERT_IMPLY(a_refuel_idle_wait, clock, reset, !refuel_pending_ff, refuel_wait_ff == '0)
   // printing never overshoots the target
   `DVS_ASSERT_IMPLY(a_count_le_target, clock, reset, 1'b1,
                     printed_total_ff <= target_total_ff)

endmodule
